/* hw/rtl/dns_packet_classify_parse_defines.svh */
// Assertion macros shared by the DNS frame classifier RTL.
`ifndef DNS_PACKET_CLASSIFY_PARSE_DEFINES_SVH
`define DNS_PACKET_CLASSIFY_PARSE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define DNSCP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define DNSCP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/dnscp_pkg.sv */
// Shared types and constants for the DNS frame classifier.
package dnscp_pkg;

  typedef logic [3:0] kind_t;

  localparam kind_t K_ICMP    = 4'd0;
  localparam kind_t K_DNS     = 4'd1;
  localparam kind_t K_QUERY   = 4'd2;
  localparam kind_t K_RESP    = 4'd3;
  localparam kind_t K_CHAR    = 4'd4;
  localparam kind_t K_END     = 4'd5;
  localparam kind_t K_SHORT   = 4'd6;
  localparam kind_t K_BADNAME = 4'd7;
  localparam kind_t K_TRUNC   = 4'd8;

  localparam logic [15:0] DNS_PORT_RESET = 16'd53;

  localparam int QAW    = 2;
  localparam int QDEPTH = 1 << QAW;

  typedef struct packed {
    logic [1:0] cnt;
    kind_t      k0;
    kind_t      k1;
  } push_t;

  typedef struct packed {
    logic [QAW:0] count;
    logic         room2;
  } qstat_t;

endpackage

/* hw/rtl/dnscp_parser.sv */
// Per-byte frame parser: header checks, DNS header and question name walk.
module dnscp_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_fire,
  input  logic [7:0]          in_data_byte,
  input  logic                in_frame_end,
  input  logic [15:0]         dns_port,
  output dnscp_pkg::push_t    push
);

  localparam logic [2:0] PH_HDR    = 3'd0;
  localparam logic [2:0] PH_DNSHDR = 3'd1;
  localparam logic [2:0] PH_LEN    = 3'd2;
  localparam logic [2:0] PH_CHARS  = 3'd3;
  localparam logic [2:0] PH_DONE   = 3'd4;

  logic [15:0] offset_r, offset_nxt;
  logic [2:0]  phase_r, phase_nxt;
  logic [7:0]  ether_hi_r, ether_hi_nxt;
  logic [15:0] sport_r, sport_nxt;
  logic [15:0] dlen_r, dlen_nxt;
  logic [7:0]  lrem_r, lrem_nxt;
  logic        lseen_r, lseen_nxt;

  logic        zero_next;
  logic [15:0] word16;
  logic [15:0] len_calc;
  logic [7:0]  lrem_dec;
  logic [16:0] label_end;
  dnscp_pkg::push_t res;

  assign word16    = {dlen_r[15:8], in_data_byte};
  assign len_calc  = word16 - 16'd8;
  assign lrem_dec  = lrem_r - 8'd1;
  assign label_end = {1'b0, offset_r} + 17'd1 + {9'd0, in_data_byte};

  always_comb begin
    phase_nxt    = phase_r;
    ether_hi_nxt = ether_hi_r;
    sport_nxt    = sport_r;
    dlen_nxt     = dlen_r;
    lrem_nxt     = lrem_r;
    lseen_nxt    = lseen_r;
    zero_next    = 1'b0;
    res.cnt      = 2'd0;
    res.k0       = dnscp_pkg::K_ICMP;
    res.k1       = dnscp_pkg::K_ICMP;
    unique case (phase_r)
      PH_HDR: begin
        unique case (offset_r)
          16'd12: ether_hi_nxt = in_data_byte;
          16'd13: begin
            if ({ether_hi_r, in_data_byte} != 16'h0800) phase_nxt = PH_DONE;
          end
          16'd23: begin
            if (in_data_byte == 8'd1) begin
              res.cnt   = 2'd1;
              res.k0    = dnscp_pkg::K_ICMP;
              phase_nxt = PH_DONE;
            end else if (in_data_byte != 8'd17) begin
              phase_nxt = PH_DONE;
            end
          end
          16'd34: sport_nxt = {in_data_byte, 8'd0};
          16'd35: sport_nxt = {sport_r[15:8], in_data_byte};
          16'd36: dlen_nxt  = {in_data_byte, 8'd0};
          16'd37: begin
            if (sport_r == dns_port || word16 == dns_port) begin
              res.cnt = 2'd1;
              res.k0  = dnscp_pkg::K_DNS;
            end else begin
              phase_nxt = PH_DONE;
            end
          end
          16'd38: dlen_nxt = {in_data_byte, 8'd0};
          16'd39: begin
            dlen_nxt = len_calc;
            if (len_calc < 16'd12) begin
              res.cnt   = 2'd1;
              res.k0    = dnscp_pkg::K_SHORT;
              phase_nxt = PH_DONE;
            end
          end
          16'd41: begin
            phase_nxt = PH_DNSHDR;
            zero_next = 1'b1;
          end
          default: ;
        endcase
      end
      PH_DNSHDR: begin
        if (offset_r == 16'd2) begin
          res.cnt = 2'd1;
          res.k0  = in_data_byte[7] ? dnscp_pkg::K_RESP : dnscp_pkg::K_QUERY;
        end else if (offset_r == 16'd11) begin
          if (dlen_r <= 16'd12) begin
            res.cnt   = 2'd1;
            res.k0    = dnscp_pkg::K_END;
            phase_nxt = PH_DONE;
          end else begin
            phase_nxt = PH_LEN;
            lseen_nxt = 1'b0;
          end
        end
      end
      PH_LEN: begin
        if (offset_r >= dlen_r || in_data_byte == 8'd0) begin
          res.cnt   = 2'd1;
          res.k0    = dnscp_pkg::K_END;
          phase_nxt = PH_DONE;
        end else if (label_end >= {1'b0, dlen_r}) begin
          phase_nxt = PH_DONE;
          if (lseen_r) begin
            res.cnt = 2'd2;
            res.k0  = dnscp_pkg::K_CHAR;
            res.k1  = dnscp_pkg::K_BADNAME;
          end else begin
            res.cnt = 2'd1;
            res.k0  = dnscp_pkg::K_BADNAME;
          end
        end else begin
          if (lseen_r) begin
            res.cnt = 2'd1;
            res.k0  = dnscp_pkg::K_CHAR;
          end
          lrem_nxt  = in_data_byte;
          lseen_nxt = 1'b1;
          phase_nxt = PH_CHARS;
        end
      end
      PH_CHARS: begin
        res.cnt  = 2'd1;
        res.k0   = dnscp_pkg::K_CHAR;
        lrem_nxt = lrem_dec;
        if (lrem_dec == 8'd0) phase_nxt = PH_LEN;
      end
      default: ;
    endcase

    if (zero_next) begin
      offset_nxt = 16'd0;
    end else if (offset_r != 16'hFFFF) begin
      offset_nxt = offset_r + 16'd1;
    end else begin
      offset_nxt = offset_r;
    end

    push = res;
    if (in_frame_end && phase_nxt != PH_DONE && res.cnt != 2'd2) begin
      if (res.cnt == 2'd0) begin
        push.k0 = dnscp_pkg::K_TRUNC;
      end else begin
        push.k1 = dnscp_pkg::K_TRUNC;
      end
      push.cnt = res.cnt + 2'd1;
    end
    if (!in_fire) push.cnt = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (in_fire && in_frame_end)) begin
      offset_r   <= 16'd0;
      phase_r    <= PH_HDR;
      ether_hi_r <= 8'd0;
      sport_r    <= 16'd0;
      dlen_r     <= 16'd0;
      lrem_r     <= 8'd0;
      lseen_r    <= 1'b0;
    end else if (in_fire) begin
      offset_r   <= offset_nxt;
      phase_r    <= phase_nxt;
      ether_hi_r <= ether_hi_nxt;
      sport_r    <= sport_nxt;
      dlen_r     <= dlen_nxt;
      lrem_r     <= lrem_nxt;
      lseen_r    <= lseen_nxt;
    end
  end

endmodule

/* hw/rtl/dnscp_result_queue.sv */
// Four-entry queue: takes up to two kinds a cycle, releases one a cycle on out_ready.
module dnscp_result_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  dnscp_pkg::push_t    push,
  output dnscp_pkg::qstat_t   stat,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [3:0]          out_kind
);

  dnscp_pkg::kind_t mem_r [dnscp_pkg::QDEPTH];
  logic [dnscp_pkg::QAW-1:0] head_r, tail_r, tail_inc;
  logic [dnscp_pkg::QAW:0]   count_r, count_nxt;
  logic                      pop;

  assign out_valid  = count_r != '0;
  assign out_kind   = mem_r[head_r];
  assign pop        = out_valid && out_ready;
  assign tail_inc   = tail_r + 1'b1;
  assign count_nxt  = count_r + {{(dnscp_pkg::QAW-1){1'b0}}, push.cnt}
                    - {{dnscp_pkg::QAW{1'b0}}, pop};
  assign stat.count = count_r;
  assign stat.room2 = count_r <= (dnscp_pkg::QAW+1)'(dnscp_pkg::QDEPTH - 2);

  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) mem_r[tail_r] <= push.k0;
    if (push.cnt == 2'd2) mem_r[tail_inc] <= push.k1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      if (pop) head_r <= head_r + 1'b1;
      tail_r  <= tail_r + push.cnt[dnscp_pkg::QAW-1:0];
      count_r <= count_nxt;
    end
  end

endmodule

/* hw/rtl/dns_packet_classify_parse.sv */
// Top level of the DNS frame classifier and question-name parser.
// Takes one frame byte per accepted word and can accept a word every cycle. Each byte
// is parsed in the cycle it is accepted and its results (at most two) go into a
// four-entry result queue that releases one kind per cycle. in_ready drops while
// fewer than two queue entries are free, so a run of bytes that each give two results
// (or a stalled output) slows input to the one-kind-per-cycle drain of that queue.
// The UDP port that marks DNS is written on cfg_wr_en and resets to 53.
`include "dns_packet_classify_parse_defines.svh"

module dns_packet_classify_parse (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_data_byte,
  input  logic        in_frame_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_kind,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data
);

  logic [15:0]         dns_port_r;
  logic                in_fire;
  logic                last_pop;
  dnscp_pkg::push_t    push;
  dnscp_pkg::qstat_t   stat;

  assign in_ready = stat.room2;
  assign in_fire  = in_valid && in_ready;
  assign last_pop = out_valid && out_ready && stat.count == 3'd1 && push.cnt == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dns_port_r <= dnscp_pkg::DNS_PORT_RESET;
    end else if (cfg_wr_en) begin
      dns_port_r <= cfg_wr_data;
    end
  end

  dnscp_parser u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_fire      (in_fire),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .dns_port     (dns_port_r),
    .push         (push)
  );

  dnscp_result_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .stat      (stat),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_kind  (out_kind)
  );

  `DNSCP_ASSERT_IMPL(a_push_needs_fire, push.cnt != 2'd0, in_fire, "push without accept")
  `DNSCP_ASSERT_IMPL(a_room_on_fire, in_fire, stat.count <= 3'd2, "accept without room")
  `DNSCP_ASSERT_NEXT(a_drain_empty, last_pop, !out_valid, "queue not empty after last pop")

endmodule

/* tb/dns_packet_classify_parse_tb.sv */
// Self-checking testbench for the DNS frame classifier and question-name parser.
`timescale 1ns / 1ps

module dns_packet_classify_parse_tb;

  localparam logic [15:0] ETH_IPV4    = 16'h0800;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  QR_RESPONSE = 8'h80;
  localparam logic [15:0] DNS_HDR_LEN = 16'd12;
  localparam logic [15:0] UDP_HDR_LEN = 16'd8;
  localparam logic [15:0] DNS_PORT_RESET = dnscp_pkg::DNS_PORT_RESET;
  localparam int          DRAIN_CYCLES = 20;
  localparam int          CYCLE_LIMIT  = 500000;
  localparam int          PHASE_BYTES  = 50;

  typedef enum logic [2:0] {
    PH_HEADER,
    PH_DNS_HDR,
    PH_LABEL_LEN,
    PH_LABEL_CHARS,
    PH_SKIP
  } parse_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_frame_end = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  out_kind;
  logic        cfg_wr_en = 1'b0;
  logic [15:0] cfg_wr_data = 16'h0000;

  frame_word_t       frame_words[$];
  frame_word_t       next_word;
  logic [7:0]        qname_bytes[$];
  dnscp_pkg::kind_t  expected_kinds[$];
  dnscp_pkg::kind_t  want_kind;

  logic [15:0]  port_cfg;
  logic [15:0]  rx_offset;
  parse_phase_t rx_phase;
  logic [15:0]  eth_type;
  logic [15:0]  udp_src;
  logic [15:0]  dns_len;
  logic [7:0]   label_left;
  logic         label_any;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int cycles = 0;
  int words_accepted = 0;
  int results_checked = 0;
  int frames_queued = 0;

  dns_packet_classify_parse dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_frame_end (in_frame_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_kind     (out_kind),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  function automatic void clear_frame_state();
    rx_offset  = 16'h0000;
    rx_phase   = PH_HEADER;
    eth_type   = 16'h0000;
    udp_src    = 16'h0000;
    dns_len    = 16'h0000;
    label_left = 8'h00;
    label_any  = 1'b0;
  endfunction

  task automatic classify_byte(input logic [7:0] b, input logic last);
    logic [15:0] pos;
    int          n;
    logic        restart;
    pos = rx_offset;
    n = 0;
    restart = 1'b0;
    case (rx_phase)
      PH_HEADER: begin
        case (pos)
          16'd12: eth_type = {b, 8'h00};
          16'd13: begin
            eth_type = {eth_type[15:8], b};
            if (eth_type != ETH_IPV4) rx_phase = PH_SKIP;
          end
          16'd23: begin
            if (b == PROTO_ICMP) begin
              expected_kinds.push_back(dnscp_pkg::K_ICMP);
              n++;
              rx_phase = PH_SKIP;
            end else if (b != PROTO_UDP) begin
              rx_phase = PH_SKIP;
            end
          end
          16'd34: udp_src = {b, 8'h00};
          16'd35: udp_src = {udp_src[15:8], b};
          16'd36: dns_len = {b, 8'h00};
          16'd37: begin
            if (udp_src == port_cfg || {dns_len[15:8], b} == port_cfg) begin
              expected_kinds.push_back(dnscp_pkg::K_DNS);
              n++;
            end else begin
              rx_phase = PH_SKIP;
            end
          end
          16'd38: dns_len = {b, 8'h00};
          16'd39: begin
            dns_len = {dns_len[15:8], b} - UDP_HDR_LEN;
            if (dns_len < DNS_HDR_LEN) begin
              expected_kinds.push_back(dnscp_pkg::K_SHORT);
              n++;
              rx_phase = PH_SKIP;
            end
          end
          16'd41: begin
            rx_phase = PH_DNS_HDR;
            restart = 1'b1;
          end
          default: ;
        endcase
      end
      PH_DNS_HDR: begin
        if (pos == 16'd2) begin
          expected_kinds.push_back((b & QR_RESPONSE) != 8'h00 ? dnscp_pkg::K_RESP
                                                              : dnscp_pkg::K_QUERY);
          n++;
        end else if (pos == 16'd11) begin
          if (dns_len <= DNS_HDR_LEN) begin
            expected_kinds.push_back(dnscp_pkg::K_END);
            n++;
            rx_phase = PH_SKIP;
          end else begin
            rx_phase = PH_LABEL_LEN;
            label_any = 1'b0;
          end
        end
      end
      PH_LABEL_LEN: begin
        if (pos >= dns_len || b == 8'h00) begin
          expected_kinds.push_back(dnscp_pkg::K_END);
          n++;
          rx_phase = PH_SKIP;
        end else begin
          if (label_any) begin
            expected_kinds.push_back(dnscp_pkg::K_CHAR);
            n++;
          end
          if (int'(pos) + 1 + int'(b) >= int'(dns_len)) begin
            expected_kinds.push_back(dnscp_pkg::K_BADNAME);
            n++;
            rx_phase = PH_SKIP;
          end else begin
            label_left = b;
            label_any = 1'b1;
            rx_phase = PH_LABEL_CHARS;
          end
        end
      end
      PH_LABEL_CHARS: begin
        expected_kinds.push_back(dnscp_pkg::K_CHAR);
        n++;
        label_left = label_left - 8'd1;
        if (label_left == 8'h00) rx_phase = PH_LABEL_LEN;
      end
      default: ;
    endcase
    if (restart) rx_offset = 16'h0000;
    else if (rx_offset != 16'hFFFF) rx_offset = rx_offset + 16'd1;
    if (last) begin
      if (rx_phase != PH_SKIP && n < 2) expected_kinds.push_back(dnscp_pkg::K_TRUNC);
      clear_frame_state();
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        classify_byte(in_data_byte, in_frame_end);
        words_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (frame_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_word = frame_words.pop_front();
          in_valid <= 1'b1;
          in_data_byte <= next_word.data;
          in_frame_end <= next_word.last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_kinds.size() == 0) begin
          $display("%0t: unexpected word, expected none, actual kind %0d", $time, out_kind);
          errors++;
        end else begin
          want_kind = expected_kinds.pop_front();
          results_checked++;
          if (out_kind !== want_kind) begin
            $display("%0t: kind mismatch, expected %0d, actual %0d", $time, want_kind,
                     out_kind);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, expected_kinds.size());
      $display("FAIL dns_packet_classify_parse");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] data, input logic last);
    frame_word_t w;
    w.data = data;
    w.last = last;
    frame_words.push_back(w);
  endtask

  task automatic queue_noise(input int len);
    for (int i = 0; i < len; i++) push_word(rand_byte(), i == len - 1);
    frames_queued++;
  endtask

  // Ethernet + fixed IPv4 + UDP + DNS header, then qname_bytes, then trailing bytes.
  task automatic queue_frame(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [15:0] sport, input logic [15:0] dport,
                             input logic [15:0] ulen, input logic [7:0] flags,
                             input int extra, input int cut);
    logic [7:0] fb[$];
    int         n;
    for (int i = 0; i < 12; i++) fb.push_back(rand_byte());
    fb.push_back(etype[15:8]);
    fb.push_back(etype[7:0]);
    for (int i = 14; i < 34; i++) fb.push_back(i == 23 ? proto : rand_byte());
    fb.push_back(sport[15:8]);
    fb.push_back(sport[7:0]);
    fb.push_back(dport[15:8]);
    fb.push_back(dport[7:0]);
    fb.push_back(ulen[15:8]);
    fb.push_back(ulen[7:0]);
    fb.push_back(rand_byte());
    fb.push_back(rand_byte());
    for (int i = 0; i < 12; i++) fb.push_back(i == 2 ? flags : rand_byte());
    foreach (qname_bytes[i]) fb.push_back(qname_bytes[i]);
    repeat (extra) fb.push_back(rand_byte());
    n = (cut > 0 && cut < fb.size()) ? cut : fb.size();
    for (int i = 0; i < n; i++) push_word(fb[i], i == n - 1);
    frames_queued++;
  endtask

  task automatic build_qname();
    int labels;
    int len;
    qname_bytes.delete();
    labels = $urandom_range(4);
    repeat (labels) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(7, 30) : $urandom_range(1, 6);
      qname_bytes.push_back(8'(len));
      repeat (len) qname_bytes.push_back(rand_byte());
    end
    case ($urandom_range(9))
      0: begin
        qname_bytes.push_back(8'($urandom_range(64, 255)));
        repeat (3) qname_bytes.push_back(rand_byte());
      end
      1: ;
      default: qname_bytes.push_back(8'h00);
    endcase
  endtask

  task automatic queue_random_frame();
    int          sel;
    int          cut;
    int          dlen;
    logic [15:0] sp;
    logic [15:0] dp;
    logic [15:0] ul;
    sel = $urandom_range(99);
    cut = ($urandom_range(99) < 15) ? $urandom_range(1, 80) : 0;
    sp = 16'($urandom_range(65535));
    dp = 16'($urandom_range(65535));
    case ($urandom_range(3))
      0: sp = port_cfg;
      1: dp = port_cfg;
      2: begin
        sp = port_cfg;
        dp = port_cfg;
      end
      default: ;
    endcase
    build_qname();
    if (sel < 60) begin
      dlen = 12 + qname_bytes.size() + $urandom_range(3);
      if ($urandom_range(7) == 0) dlen = 12 + $urandom_range(qname_bytes.size());
      ul = 16'(dlen + 8);
      queue_frame(ETH_IPV4, PROTO_UDP, sp, dp, ul, rand_byte(), $urandom_range(3), cut);
    end else if (sel < 68) begin
      ul = 16'(($urandom_range(1) != 0) ? $urandom_range(7) : $urandom_range(8, 20));
      queue_frame(ETH_IPV4, PROTO_UDP, sp, dp, ul, rand_byte(), $urandom_range(3), cut);
    end else if (sel < 74) begin
      queue_frame(ETH_IPV4, PROTO_ICMP, sp, dp, {8'h00, rand_byte()}, rand_byte(), 0, cut);
    end else if (sel < 80) begin
      queue_frame(ETH_IPV4, rand_byte(), sp, dp, 16'd40, rand_byte(), 0, cut);
    end else if (sel < 86) begin
      queue_frame(16'($urandom_range(65535)), PROTO_UDP, sp, dp, 16'd40, rand_byte(), 0,
                  cut);
    end else if (sel < 90) begin
      queue_frame(ETH_IPV4, PROTO_UDP, 16'($urandom_range(65535)),
                  16'($urandom_range(65535)), 16'($urandom_range(65535)), rand_byte(),
                  0, cut);
    end else begin
      queue_noise($urandom_range(1, 50));
    end
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (frame_words.size() != 0 || in_valid || expected_kinds.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_port(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    port_cfg = value;
  endtask

  task automatic run_random(input int send_pct, input int recv_pct);
    int target;
    @(negedge clk);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
    target = words_accepted + frame_words.size() + PHASE_BYTES;
    while (words_accepted + frame_words.size() < target) queue_random_frame();
    wait_idle();
  endtask

  initial begin
    port_cfg = DNS_PORT_RESET;
    clear_frame_state();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    queue_noise(1);
    queue_noise(13);
    qname_bytes.delete();
    queue_frame(16'h86DD, PROTO_UDP, DNS_PORT_RESET, DNS_PORT_RESET, 16'd20, 8'h00, 0, 0);
    queue_frame(ETH_IPV4, PROTO_ICMP, 16'h0000, 16'h0000, 16'h0000, 8'h00, 2, 0);
    queue_frame(ETH_IPV4, PROTO_TCP, DNS_PORT_RESET, DNS_PORT_RESET, 16'd20, 8'h00, 0, 0);
    queue_frame(ETH_IPV4, PROTO_UDP, 16'd1000, 16'd2000, 16'd40, 8'h00, 0, 0);
    qname_bytes = '{8'd1, 8'h61, 8'd2, 8'h62, 8'h63, 8'h00};
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd4242, 16'd26, 8'h00, 1, 0);
    qname_bytes.delete();
    queue_frame(ETH_IPV4, PROTO_UDP, 16'd5353, DNS_PORT_RESET, 16'd20, QR_RESPONSE, 1, 0);
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd19, 8'h00, 2, 0);
    qname_bytes = '{8'd3, 8'h78, 8'h79, 8'h7A};
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd0, 8'h00, 0, 0);
    qname_bytes = '{8'd1, 8'h78, 8'd200, 8'h61, 8'h62};
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd25, 8'h00, 1, 0);
    qname_bytes = '{8'd3, 8'h61, 8'h62, 8'h63};
    queue_frame(ETH_IPV4, PROTO_UDP, 16'd7, DNS_PORT_RESET, 16'd24, 8'h00, 2, 0);
    qname_bytes = '{8'd2, 8'hFF, 8'h00, 8'h00};
    queue_frame(ETH_IPV4, PROTO_UDP, 16'hFFFF, DNS_PORT_RESET, 16'hFFFF, 8'hFF, 0, 0);
    qname_bytes = '{8'd4, 8'h61, 8'h62, 8'h63, 8'h64, 8'h00};
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd26, 8'h00, 0, 45);
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd26, 8'h00, 0, 56);
    qname_bytes = '{8'd1, 8'h61, 8'd1, 8'h62, 8'h00};
    queue_frame(ETH_IPV4, PROTO_UDP, DNS_PORT_RESET, 16'd7, 16'd25, 8'h00, 0, 57);
    wait_idle();

    run_random(0, 0);
    write_port(16'h0000);
    run_random(50, 0);
    write_port(16'hFFFF);
    run_random(0, 50);
    write_port(16'($urandom_range(65535)));
    run_random(14, 14);
    write_port(DNS_PORT_RESET);
    run_random(0, 0);

    if (expected_kinds.size() != 0) begin
      $display("%0t: expected 0 outstanding results, actual %0d", $time,
               expected_kinds.size());
      errors++;
    end
    $display("Sent %0d frames (%0d bytes) over five port settings and four idle mixes;",
             frames_queued, words_accepted);
    $display("checked %0d result words, %0d errors", results_checked, errors);
    if (errors == 0) begin
      $display("PASS dns_packet_classify_parse");
    end else begin
      $display("FAIL dns_packet_classify_parse");
    end
    $finish;
  end

endmodule
